// File: rtl/eight_bit_bcd_alu_with_flags_top_defines.svh
// Assertion macros for the byte ALU with decimal mode.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef EIGHT_BIT_BCD_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define EIGHT_BIT_BCD_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge out of reset
`define EBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset
`define EBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/eba_pkg.sv
// Shared types, operation codes, flag positions and decimal fix-up constants
// for the byte ALU with decimal mode. Depends on nothing.
package eba_pkg;

    // Operation codes
    localparam logic [3:0] FUNC_ADC = 4'd0;
    localparam logic [3:0] FUNC_SBC = 4'd1;
    localparam logic [3:0] FUNC_CMP = 4'd2;
    localparam logic [3:0] FUNC_AND = 4'd3;
    localparam logic [3:0] FUNC_ORA = 4'd4;
    localparam logic [3:0] FUNC_EOR = 4'd5;
    localparam logic [3:0] FUNC_ASL = 4'd6;
    localparam logic [3:0] FUNC_LSR = 4'd7;
    localparam logic [3:0] FUNC_ROL = 4'd8;
    localparam logic [3:0] FUNC_ROR = 4'd9;
    localparam logic [3:0] FUNC_BIT = 4'd10;
    localparam logic [3:0] FUNC_INC = 4'd11;
    localparam logic [3:0] FUNC_DEC = 4'd12;

    // Status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Decimal fix-up constants
    localparam logic [4:0] DEC_LO_LIMIT = 5'h0a;
    localparam logic [3:0] DEC_LO_FIX   = 4'h6;
    localparam logic [8:0] DEC_HI_LIMIT = 9'h0a0;
    localparam logic [7:0] DEC_HI_FIX   = 8'h60;
    localparam logic [3:0] SBC_LO_FIX   = 4'ha;
    localparam logic [3:0] SBC_HI_FIX   = 4'ha;

    // Input item
    typedef struct packed {
        logic [3:0] func;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic [7:0] status_in;
    } req_t;

    // Result item
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status_out;
    } rsp_t;

    // Stage 2: low nibble done, simple operations finished
    typedef struct packed {
        logic [3:0] func;
        logic [7:0] reg_value;
        logic [7:0] opnd_b;
        logic [7:0] status;
        logic [4:0] lo_sum;
        logic [4:0] lo_dec;
        logic [7:0] simple_result;
        logic [7:0] simple_status;
    } s2_t;

    // Stage 3: full binary and decimal sums
    typedef struct packed {
        logic [3:0] func;
        logic [7:0] status;
        logic [8:0] sum;
        logic       carry7;
        logic [8:0] dec_sum;
        logic       dec_ovf;
        logic       lo_carry;
        logic [7:0] simple_result;
        logic [7:0] simple_status;
    } s3_t;

    // Update N and Z from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] r);
        logic [7:0] o;
        o         = st;
        o[FLAG_Z] = (r == 8'h00);
        o[FLAG_N] = r[7];
        return o;
    endfunction

endpackage

// File: rtl/eight_bit_bcd_alu_with_flags_top.sv
// Byte ALU with status flags and decimal add/subtract, four register stages.
// Depends on eba_pkg and eight_bit_bcd_alu_with_flags_top_defines.svh.
//
//   channel | valid     | ready     | payload        | moves
//   --------+-----------+-----------+----------------+------------------------
//   req     | req_valid | req_ready | req (req_t)    | operation, bytes, status
//   rsp     | rsp_valid | rsp_ready | rsp (rsp_t)    | result byte, new status
//
// One item enters per cycle while no stage is held; rsp_valid for an item rises
// once it has passed the four register stages (input, low nibble, full sums,
// output with flag assembly), and it can then leave when rsp_ready is high.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled rsp holds the output stage, and each stage holds while the one
// after it is full and held, so nothing is lost or repeated.
`include "eight_bit_bcd_alu_with_flags_top_defines.svh"

module eight_bit_bcd_alu_with_flags_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  eba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output eba_pkg::rsp_t rsp
);

    eba_pkg::req_t s1_reg;
    eba_pkg::s2_t  s2_reg, s2_next;
    eba_pkg::s3_t  s3_reg, s3_next;
    eba_pkg::rsp_t s4_reg, s4_next;
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          rdy1, rdy2, rdy3, rdy4;

    // Stage ready chain: a stage loads when empty or when it moves on
    assign rdy4      = !v4_reg || rsp_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req_ready = rdy1;
    assign rsp_valid = v4_reg;
    assign rsp       = s4_reg;

    // Stage 1 to 2: operand select, low nibble sum, simple operations
    always_comb
    begin
        logic [7:0] a;
        logic [7:0] m;
        logic [7:0] st;
        logic [7:0] b;
        logic       cin;
        logic       cin_eff;
        logic [4:0] lo;
        logic [7:0] r;
        logic [7:0] so;

        a   = s1_reg.reg_value;
        m   = s1_reg.operand;
        st  = s1_reg.status_in;
        cin = st[eba_pkg::FLAG_C];

        b       = ((s1_reg.func == eba_pkg::FUNC_SBC) || (s1_reg.func == eba_pkg::FUNC_CMP))
                  ? ~m : m;
        cin_eff = (s1_reg.func == eba_pkg::FUNC_CMP) ? 1'b1 : cin;
        lo      = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin_eff};

        r  = 8'h00;
        so = st;
        unique case (s1_reg.func)
            eba_pkg::FUNC_AND:
            begin
                r  = a & m;
                so = eba_pkg::set_nz(st, r);
            end
            eba_pkg::FUNC_ORA:
            begin
                r  = a | m;
                so = eba_pkg::set_nz(st, r);
            end
            eba_pkg::FUNC_EOR:
            begin
                r  = a ^ m;
                so = eba_pkg::set_nz(st, r);
            end
            eba_pkg::FUNC_ASL:
            begin
                r                  = {m[6:0], 1'b0};
                so                 = eba_pkg::set_nz(st, r);
                so[eba_pkg::FLAG_C] = m[7];
            end
            eba_pkg::FUNC_LSR:
            begin
                r                  = {1'b0, m[7:1]};
                so                 = eba_pkg::set_nz(st, r);
                so[eba_pkg::FLAG_C] = m[0];
            end
            eba_pkg::FUNC_ROL:
            begin
                r                  = {m[6:0], cin};
                so                 = eba_pkg::set_nz(st, r);
                so[eba_pkg::FLAG_C] = m[7];
            end
            eba_pkg::FUNC_ROR:
            begin
                r                  = {cin, m[7:1]};
                so                 = eba_pkg::set_nz(st, r);
                so[eba_pkg::FLAG_C] = m[0];
            end
            eba_pkg::FUNC_BIT:
            begin
                r                  = a;
                so[eba_pkg::FLAG_Z] = ((a & m) == 8'h00);
                so[eba_pkg::FLAG_N] = m[7];
                so[eba_pkg::FLAG_V] = m[6];
            end
            eba_pkg::FUNC_INC:
            begin
                r  = m + 8'd1;
                so = eba_pkg::set_nz(st, r);
            end
            eba_pkg::FUNC_DEC:
            begin
                r  = m - 8'd1;
                so = eba_pkg::set_nz(st, r);
            end
            default:
            begin
                r  = 8'h00;
                so = st;
            end
        endcase

        s2_next.func          = s1_reg.func;
        s2_next.reg_value     = a;
        s2_next.opnd_b        = b;
        s2_next.status        = st;
        s2_next.lo_sum        = lo;
        // Decimal low nibble: add six and force the carry into the high nibble
        s2_next.lo_dec        = (lo >= eba_pkg::DEC_LO_LIMIT)
                                ? {1'b1, lo[3:0] + eba_pkg::DEC_LO_FIX} : lo;
        s2_next.simple_result = r;
        s2_next.simple_status = so;
    end

    // Stage 2 to 3: high nibble, binary sum, decimal sum and its overflow
    always_comb
    begin
        logic [7:0] a;
        logic [7:0] b;
        logic [4:0] hi;
        logic [3:0] lo7;
        logic [9:0] sv;

        a   = s2_reg.reg_value;
        b   = s2_reg.opnd_b;
        hi  = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'b0, s2_reg.lo_sum[4]};
        lo7 = {1'b0, a[6:4]} + {1'b0, b[6:4]} + {3'b0, s2_reg.lo_sum[4]};
        sv  = {{2{a[7]}}, a[7:4], 4'b0} + {{2{b[7]}}, b[7:4], 4'b0}
              + {5'b0, s2_reg.lo_dec};

        s3_next.func          = s2_reg.func;
        s3_next.status        = s2_reg.status;
        s3_next.sum           = {hi, s2_reg.lo_sum[3:0]};
        s3_next.carry7        = lo7[3];
        s3_next.dec_sum       = {1'b0, a[7:4], 4'b0} + {1'b0, b[7:4], 4'b0}
                                + {4'b0, s2_reg.lo_dec};
        s3_next.dec_ovf       = !((sv[9:7] == 3'b000) || (sv[9:7] == 3'b111));
        s3_next.lo_carry      = s2_reg.lo_sum[4];
        s3_next.simple_result = s2_reg.simple_result;
        s3_next.simple_status = s2_reg.simple_status;
    end

    // Stage 3 to 4: decimal corrections and flag assembly
    always_comb
    begin
        logic [7:0] st;
        logic [7:0] st_bin;
        logic [7:0] r;
        logic [7:0] so;
        logic       dec;
        logic       hi_fix;

        st     = s3_reg.status;
        dec    = st[eba_pkg::FLAG_D];
        hi_fix = (s3_reg.dec_sum >= eba_pkg::DEC_HI_LIMIT);

        st_bin                  = eba_pkg::set_nz(st, s3_reg.sum[7:0]);
        st_bin[eba_pkg::FLAG_C] = s3_reg.sum[8];
        st_bin[eba_pkg::FLAG_V] = s3_reg.carry7 ^ s3_reg.sum[8];

        r  = s3_reg.simple_result;
        so = s3_reg.simple_status;
        unique case (s3_reg.func)
            eba_pkg::FUNC_ADC:
            begin
                if (dec)
                begin
                    r                   = s3_reg.dec_sum[7:0]
                                          + (hi_fix ? eba_pkg::DEC_HI_FIX : 8'h00);
                    so                  = st;
                    so[eba_pkg::FLAG_Z] = (s3_reg.sum[7:0] == 8'h00);
                    so[eba_pkg::FLAG_N] = s3_reg.dec_sum[7];
                    so[eba_pkg::FLAG_V] = s3_reg.dec_ovf;
                    so[eba_pkg::FLAG_C] = hi_fix;
                end
                else
                begin
                    r  = s3_reg.sum[7:0];
                    so = st_bin;
                end
            end
            eba_pkg::FUNC_SBC:
            begin
                r  = s3_reg.sum[7:0];
                so = st_bin;
                if (dec)
                begin
                    // Low nibble borrow takes six off the low nibble
                    if (!s3_reg.lo_carry)
                    begin
                        r[3:0] = r[3:0] + eba_pkg::SBC_LO_FIX;
                    end
                    // Borrow out of bit 7 takes 0x60 off the byte
                    if (!s3_reg.sum[8])
                    begin
                        r[7:4] = r[7:4] + eba_pkg::SBC_HI_FIX;
                    end
                end
            end
            eba_pkg::FUNC_CMP:
            begin
                r                   = s3_reg.sum[7:0];
                so                  = eba_pkg::set_nz(st, r);
                so[eba_pkg::FLAG_C] = s3_reg.sum[8];
            end
            default:
            begin
                r  = s3_reg.simple_result;
                so = s3_reg.simple_status;
            end
        endcase

        s4_next.result     = r;
        s4_next.status_out = so;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Advance payloads; hold while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (rdy1 && req_valid)
        begin
            s1_reg <= req;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    // Checks on the stage control
    `EBA_ASSERT_NXT(a_s3_hold, v3_reg && !rdy4, v3_reg && $stable(s3_reg), "stage 3 lost a stalled item")
    `EBA_ASSERT_NXT(a_s1_load, req_ready, v1_reg == $past(req_valid), "stage 1 valid does not follow req")
    `EBA_ASSERT_NXT(a_unused_op, v3_reg && rdy4 && (s3_reg.func > eba_pkg::FUNC_DEC), (rsp.result == 8'h00) && (rsp.status_out == $past(s3_reg.status)), "unused code changed the item")
    `EBA_ASSERT_IMP(a_out_source, $rose(rsp_valid), $past(v3_reg), "result appeared without a stage 3 item")

endmodule
